// File: hw/rtl/psvm_pkg.sv
// Shared types and constants for the polyphonic sample voice mixer.
// No dependencies.
`default_nettype none
package psvm_pkg;

   localparam int MID_VALUE    = 32768;
   localparam int REL_STEPS    = 4096;
   localparam int REL_BITS     = 12;
   localparam int ATT_STEPS    = 32;
   localparam int ATT_BITS     = 5;
   localparam int POS_W        = 21;
   localparam int LEN_W        = 20;
   localparam int VEL_IDX_W    = 9;
   localparam int VEL_W        = 10;
   localparam int SAMPLE_W     = 16;
   localparam int SUM_W        = 21;
   localparam int MUL_B_W      = 13;
   localparam int MASK_W       = 24;
   localparam int VEL_ENTRIES  = 125;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_PRESS   = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_WRITE   = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      OP_PASS = 4'b0001,
      OP_VEL  = 4'b0010,
      OP_REL  = 4'b0100,
      OP_ATT  = 4'b1000
   } mac_op_type;

   localparam logic [VEL_W-1:0] VEL_TABLE [0:VEL_ENTRIES-1] = '{
      10'd512, 10'd487, 10'd463, 10'd440, 10'd419, 10'd398, 10'd379, 10'd360, 10'd343,
      10'd326, 10'd310, 10'd295, 10'd280, 10'd267, 10'd254, 10'd241, 10'd230, 10'd218,
      10'd208, 10'd198, 10'd188, 10'd179, 10'd170, 10'd162, 10'd154, 10'd146, 10'd139,
      10'd132, 10'd126, 10'd120, 10'd114, 10'd108, 10'd103, 10'd98,  10'd93,  10'd88,
      10'd84,  10'd80,  10'd76,  10'd72,  10'd69,  10'd65,  10'd62,  10'd59,  10'd56,
      10'd53,  10'd51,  10'd48,  10'd46,  10'd44,  10'd42,  10'd39,  10'd38,  10'd36,
      10'd34,  10'd32,  10'd31,  10'd29,  10'd28,  10'd26,  10'd25,  10'd24,  10'd23,
      10'd21,  10'd20,  10'd19,  10'd18,  10'd17,  10'd17,  10'd16,  10'd15,  10'd14,
      10'd13,  10'd13,  10'd12,  10'd12,  10'd11,  10'd10,  10'd10,  10'd9,   10'd9,
      10'd8,   10'd8,   10'd8,   10'd7,   10'd7,   10'd6,   10'd6,   10'd6,   10'd5,
      10'd5,   10'd5,   10'd5,   10'd4,   10'd4,   10'd4,   10'd4,   10'd4,   10'd3,
      10'd3,   10'd3,   10'd3,   10'd3,   10'd2,   10'd2,   10'd2,   10'd2,   10'd2,
      10'd2,   10'd2,   10'd2,   10'd1,   10'd1,   10'd1,   10'd1,   10'd1,   10'd1,
      10'd1,   10'd1,   10'd1,   10'd1,   10'd1,   10'd1,   10'd1,   10'd1
   };

   // velocity curve; entries past the listed curve are zero
   function automatic logic [VEL_W-1:0] velocity_gain(input logic [VEL_IDX_W-1:0] idx);
      logic [VEL_W-1:0] g;
      g = '0;
      if (idx < VEL_IDX_W'(VEL_ENTRIES)) begin
         g = VEL_TABLE[idx[6:0]];
      end
      return g;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/psvm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module psvm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 12288
) (
   input  wire logic                     clock,
   input  wire logic                     write_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         write_data,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[addr] <= write_data;
      end
      read_data <= mem_ff[addr];
   end

endmodule
`default_nettype wire

// File: hw/rtl/psvm_mac.sv
// Shared multiply and arithmetic-shift unit with registered result.
// Depends on psvm_pkg.
`default_nettype none
module psvm_mac
   import psvm_pkg::*;
#(
   parameter int AW        = 18,
   parameter int VEL_SHIFT = 9
) (
   input  wire logic                  clock,
   input  wire mac_op_type            op,
   input  wire logic signed [AW-1:0]  op_a,
   input  wire logic [MUL_B_W-1:0]    op_b,
   output logic signed [AW-1:0]       q_ff
);

   localparam int PW = AW + MUL_B_W + 1;

   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] shifted;
   logic signed [AW-1:0] q_in;

   assign prod = PW'(op_a) * $signed({1'b0, op_b});

   always_comb begin
      case (op)
         OP_VEL:  shifted = prod >>> VEL_SHIFT;
         OP_REL:  shifted = prod >>> REL_BITS;
         OP_ATT:  shifted = prod >>> ATT_BITS;
         default: shifted = prod;
      endcase
      q_in = shifted[AW-1:0];
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

endmodule
`default_nettype wire

// File: hw/rtl/polyphonic_sample_voice_mixer_top.sv
// Polyphonic sample voice mixer: top level with sequencer, per-voice state and sample RAM.
// Depends on psvm_pkg, psvm_ram and psvm_mac.
//
// Takes one request at a time and returns one response per request. Press, release and
// sample-write requests pass through the done state before their response. A tick with
// enable set first loads the word held from the previous tick, then walks all voices
// through one shared multiplier: an idle voice gets only the state update; a sounding
// voice gets the state update and RAM read, velocity, release and attack multiplies and
// the accumulate; a voice that ends stops after the release step.
// The sample RAM holds VOICES rings of RING_DEPTH words and is undefined until written.
`default_nettype none
module polyphonic_sample_voice_mixer_top
   import psvm_pkg::*;
#(
   parameter int VOICES         = 24,
   parameter int RING_DEPTH     = 512,
   parameter int VELOCITY_SHIFT = 9
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [4:0]  req_voice,
   input  wire logic [8:0]  req_address,
   input  wire logic [15:0] req_sample,
   input  wire logic [19:0] req_note_length,
   input  wire logic [8:0]  req_velocity_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_sample_valid,
   output logic [15:0]      rsp_sample_word,
   output logic [23:0]      rsp_refill_top_mask,
   output logic [23:0]      rsp_active_mask,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic        csr_write_data
);

   localparam int VB   = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int RB   = $clog2(RING_DEPTH);
   localparam int AW   = SAMPLE_W + VEL_W + 1 - VELOCITY_SHIFT;
   localparam int MEMD = VOICES * (2 ** RB);
   localparam int MAW  = $clog2(MEMD);
   localparam logic [RB-1:0] HALF_IDX = RB'(RING_DEPTH / 2);
   localparam logic [RB-1:0] LAST_IDX = RB'(RING_DEPTH - 1);

   typedef enum logic [4:0] {
      PH_IDLE      = 5'b00001,
      PH_PRESSED   = 5'b00010,
      PH_PLAYING   = 5'b00100,
      PH_RELEASED  = 5'b01000,
      PH_RELEASING = 5'b10000
   } phase_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_PREP = 7'b0000010,
      ST_VEL  = 7'b0000100,
      ST_REL  = 7'b0001000,
      ST_ATT  = 7'b0010000,
      ST_ACC  = 7'b0100000,
      ST_DONE = 7'b1000000
   } seq_type;

   phase_type         phase_ff [VOICES];
   logic [POS_W-1:0]  pos_ff   [VOICES];
   logic [RB-1:0]     ring_ff  [VOICES];
   logic [LEN_W-1:0]  relp_ff  [VOICES];
   logic [LEN_W-1:0]  len_ff   [VOICES];
   logic [VEL_IDX_W-1:0] vel_ff [VOICES];
   logic [VOICES-1:0] top_ff;

   seq_type           state_ff, state_in;
   logic [VB-1:0]     vcnt_ff;
   logic [POS_W-1:0]  cur_ff;
   logic [LEN_W-1:0]  rel_ff;
   logic [RB-1:0]     idx_ff;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  held_ff;
   logic              enable_ff, mode_ff;
   logic              rsp_valid_ff, smp_valid_ff;
   logic [15:0]       word_ff;
   logic [23:0]       top_mask_ff, act_mask_ff;

   logic              accept, is_tick, voice_ok, addr_ok, last_voice, voice_done;
   logic [6:0]        voice_ext;
   logic [12:0]       addr_ext;
   logic [VB-1:0]     vsel;
   logic [RB-1:0]     asel;
   phase_type         ph, ph_n;
   logic [LEN_W-1:0]  len_cur, lmr, rel_n;
   logic [POS_W-1:0]  cur_n;
   logic [RB-1:0]     idx_n, idx_inc;
   logic [POS_W:0]    r_plus;
   logic [POS_W:0]    rel_end;
   logic              in_rel, kill;
   logic [LEN_W:0]    span;
   logic [SUM_W-1:0]  dac_t;
   logic [15:0]       word_n;
   logic [23:0]       top_mask, act_mask;

   logic              ram_we;
   logic [MAW-1:0]    ram_addr;
   logic [SAMPLE_W-1:0] ram_rd;

   mac_op_type        mop;
   logic signed [AW-1:0] ma;
   logic [MUL_B_W-1:0] mb;
   logic signed [AW-1:0] mq;
   logic signed [AW+SUM_W-1:0] mq_ext;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign is_tick   = (cmd_type'(req_cmd) == CMD_TICK);
   assign voice_ext = {2'b00, req_voice};
   assign addr_ext  = {4'b0000, req_address};
   assign vsel      = voice_ext[VB-1:0];
   assign asel      = addr_ext[RB-1:0];
   assign voice_ok  = voice_ext < 7'(VOICES);
   assign addr_ok   = addr_ext < 13'(RING_DEPTH);
   assign last_voice = (vcnt_ff == VB'(VOICES - 1));

   // per-voice state update at the head of each voice
   always_comb begin
      ph      = phase_ff[vcnt_ff];
      len_cur = len_ff[vcnt_ff];
      lmr     = (len_cur >= LEN_W'(REL_STEPS)) ? len_cur - LEN_W'(REL_STEPS) : '0;
      r_plus  = {1'b0, pos_ff[vcnt_ff]} + (POS_W + 1)'(REL_STEPS);
      cur_n   = pos_ff[vcnt_ff];
      rel_n   = relp_ff[vcnt_ff];
      idx_n   = ring_ff[vcnt_ff];
      ph_n    = ph;
      case (ph)
         PH_PRESSED: begin
            cur_n = '0;
            rel_n = lmr;
            idx_n = '0;
            ph_n  = PH_PLAYING;
         end
         PH_RELEASED: begin
            if (r_plus > (POS_W + 1)'(len_cur)) begin
               rel_n = lmr;
            end else begin
               rel_n = pos_ff[vcnt_ff][LEN_W-1:0];
            end
            ph_n = PH_RELEASING;
         end
         default: ;
      endcase
   end

   assign idx_inc = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
   assign rel_end = (POS_W + 1)'(rel_ff) + (POS_W + 1)'(REL_STEPS);
   assign in_rel  = cur_ff > POS_W'(rel_ff);
   assign kill    = in_rel && ((POS_W + 1)'(cur_ff) > rel_end);
   assign span    = (LEN_W + 1)'(cur_ff) - (LEN_W + 1)'(rel_ff);

   // shared multiplier operand select
   always_comb begin
      mop = OP_PASS;
      ma  = mq;
      mb  = MUL_B_W'(1);
      case (state_ff)
         ST_VEL: begin
            mop = OP_VEL;
            ma  = AW'($signed({~ram_rd[SAMPLE_W-1], ram_rd[SAMPLE_W-2:0]}));
            mb  = MUL_B_W'(velocity_gain(vel_ff[vcnt_ff]));
         end
         ST_REL: begin
            if (in_rel) begin
               mop = OP_REL;
               mb  = MUL_B_W'(REL_STEPS) - span[MUL_B_W-1:0];
            end
         end
         ST_ATT: begin
            if (cur_ff < POS_W'(ATT_STEPS)) begin
               mop = OP_ATT;
               mb  = MUL_B_W'(cur_ff[ATT_BITS-1:0]);
            end
         end
         default: ;
      endcase
   end

   psvm_mac #(.AW(AW), .VEL_SHIFT(VELOCITY_SHIFT)) u_mac (
      .clock (clock),
      .op    (mop),
      .op_a  (ma),
      .op_b  (mb),
      .q_ff  (mq)
   );

   assign mq_ext = (AW + SUM_W)'(mq);
   assign sum_in = (state_ff == ST_ACC) ? sum_ff + mq_ext[SUM_W-1:0] : sum_ff;

   assign ram_we   = accept && (cmd_type'(req_cmd) == CMD_WRITE) && voice_ok && addr_ok;
   assign ram_addr = ram_we ? MAW'({vsel, asel}) : MAW'({vcnt_ff, idx_n});

   psvm_ram #(.WIDTH(SAMPLE_W), .DEPTH(MEMD)) u_ram (
      .clock      (clock),
      .write_en   (ram_we),
      .addr       (ram_addr),
      .write_data (req_sample),
      .read_data  (ram_rd)
   );

   // output word from the held sum
   always_comb begin
      dac_t  = held_ff + SUM_W'(MID_VALUE);
      word_n = mode_ff ? held_ff[18:3] : dac_t[19:4] + 16'(MID_VALUE);
   end

   always_comb begin
      voice_done = 1'b0;
      state_in   = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (is_tick && enable_ff) ? ST_PREP : ST_DONE;
            end
         end
         ST_PREP: begin
            if (ph == PH_IDLE) begin
               voice_done = 1'b1;
            end else begin
               state_in = ST_VEL;
            end
         end
         ST_VEL:  state_in = ST_REL;
         ST_REL: begin
            if (kill) begin
               voice_done = 1'b1;
            end else begin
               state_in = ST_ATT;
            end
         end
         ST_ATT:  state_in = ST_ACC;
         ST_ACC:  voice_done = 1'b1;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (voice_done) begin
         state_in = last_voice ? ST_DONE : ST_PREP;
      end
   end

   for (genvar i = 0; i < MASK_W; i++) begin : g_mask
      if (i < VOICES) begin : g_on
         assign top_mask[i] = top_ff[i];
         assign act_mask[i] = (phase_ff[i] != PH_IDLE);
      end else begin : g_off
         assign top_mask[i] = 1'b0;
         assign act_mask[i] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcnt_ff      <= '0;
         held_ff      <= '0;
         enable_ff    <= 1'b0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         top_ff       <= '0;
         for (int v = 0; v < VOICES; v++) begin
            phase_ff[v] <= PH_IDLE;
            pos_ff[v]   <= '1;
            ring_ff[v]  <= '0;
            relp_ff[v]  <= '0;
            len_ff[v]   <= '0;
            vel_ff[v]   <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            if (csr_index) begin
               mode_ff <= csr_write_data;
            end else begin
               enable_ff <= csr_write_data;
            end
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_DONE) begin
            rsp_valid_ff <= 1'b1;
         end
         if (accept) begin
            vcnt_ff <= '0;
            if (!is_tick && voice_ok) begin
               case (cmd_type'(req_cmd))
                  CMD_PRESS: begin
                     phase_ff[vsel] <= PH_PRESSED;
                     len_ff[vsel]   <= req_note_length;
                     vel_ff[vsel]   <= req_velocity_index;
                  end
                  CMD_RELEASE: begin
                     if (phase_ff[vsel] == PH_PLAYING) begin
                        phase_ff[vsel] <= PH_RELEASED;
                     end
                  end
                  default: ;
               endcase
            end
         end
         if (voice_done) begin
            vcnt_ff <= last_voice ? '0 : vcnt_ff + 1'b1;
            if (last_voice) begin
               held_ff <= sum_in;
            end
         end
         if ((state_ff == ST_PREP) && (ph != PH_IDLE)) begin
            phase_ff[vcnt_ff] <= ph_n;
            pos_ff[vcnt_ff]   <= cur_n;
            relp_ff[vcnt_ff]  <= rel_n;
            ring_ff[vcnt_ff]  <= idx_n;
         end
         if ((state_ff == ST_REL) && kill) begin
            phase_ff[vcnt_ff] <= PH_IDLE;
            pos_ff[vcnt_ff]   <= '1;
            top_ff[vcnt_ff]   <= 1'b0;
         end
         if (state_ff == ST_ACC) begin
            pos_ff[vcnt_ff]  <= cur_ff + 1'b1;
            ring_ff[vcnt_ff] <= idx_inc;
            if (idx_ff == '0) begin
               top_ff[vcnt_ff] <= 1'b1;
            end else if (idx_ff == HALF_IDX) begin
               top_ff[vcnt_ff] <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sum_ff       <= '0;
         smp_valid_ff <= is_tick && enable_ff;
         word_ff      <= (is_tick && enable_ff) ? word_n : '0;
      end else begin
         sum_ff <= sum_in;
      end
      if (state_ff == ST_PREP) begin
         cur_ff <= cur_n;
         rel_ff <= rel_n;
         idx_ff <= idx_n;
      end
      if (state_ff == ST_DONE) begin
         top_mask_ff <= top_mask;
         act_mask_ff <= act_mask;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sample_valid    = smp_valid_ff;
   assign rsp_sample_word     = word_ff;
   assign rsp_refill_top_mask = top_mask_ff;
   assign rsp_active_mask     = act_mask_ff;

endmodule
`default_nettype wire
